>>> rtl/rris_pkg.sv
`timescale 1ns / 1ps

package rris_pkg;

  // default sizes
  localparam int unsigned NUM_KEYS_DEF      = 10;
  localparam int unsigned INTERVAL_BITS_DEF = 16;

  // fixed widths of the register and field formats
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned SLOT_W      = 16;
  localparam int unsigned SLOTS_PER_W = 4;
  localparam int unsigned CHAN_W      = 4;
  localparam int unsigned MASK_W      = 12;

  // wait loaded after a scan that finds nothing
  localparam logic [COUNT_W-1:0] IDLE_WAIT_MS = COUNT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_MASK  = 3'd0,
    CFG_GLOBAL_IVL   = 3'd1,
    CFG_IVL_0_3      = 3'd2,
    CFG_IVL_4_7      = 3'd3,
    CFG_IVL_8_11     = 3'd4
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic tick;   // tick beat accepted
    logic scan;   // check one channel
    logic emit;   // move result into output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;      // wait running or halted, no scan this tick
    logic hit;       // current channel eligible
    logic last;      // current channel is the last of the scan
    logic out_free;  // output register can take a result
  } dp_status_t;

endpackage

>>> rtl/round_robin_interval_scheduler_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// tick      in         in_valid_i/in_ready_o   halt_i
// result    out        out_valid_o/out_ready_i granted_o, channel_number_o, idle_scan_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a tick goes from accept straight to emit while the wait count runs or halt is set,
// and else scans k = 1 .. NUM_KEYS channels, one channel compare per cycle in the loop
// reset leaves every elapsed count saturated, pointer and wait count at zero
// the result sits in an output register; the next tick beat is taken while it waits,
// and that tick's own result is held back until the register frees up
// config beats are always taken, and are meant to arrive only while the block is idle

module round_robin_interval_scheduler_top #(
  parameter int unsigned NUM_KEYS      = rris_pkg::NUM_KEYS_DEF,
  parameter int unsigned INTERVAL_BITS = rris_pkg::INTERVAL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            halt_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            granted_o,
  output logic [rris_pkg::CHAN_W-1:0]     channel_number_o,
  output logic                            idle_scan_o,
  // config channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rris_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rris_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rris_pkg::dp_cmd_t    cmd;
  rris_pkg::dp_status_t status;

  // register writes land in the cycle after the beat, so config never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer: accept tick, walk the scan, hand off the result
  rris_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counts, pointer, wait count, config registers and output register
  rris_dp #(
    .NUM_KEYS      (NUM_KEYS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .halt_i           (halt_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .granted_o        (granted_o),
    .channel_number_o (channel_number_o),
    .idle_scan_o      (idle_scan_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

>>> rtl/rris_ctrl.sv
`timescale 1ns / 1ps

module rris_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rris_pkg::dp_status_t status_i,
  output rris_pkg::dp_cmd_t    cmd_o
);

  rris_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rris_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tick = 1'b1;
          state_d    = status_i.skip ? rris_pkg::ST_EMIT : rris_pkg::ST_SCAN;
        end
      end
      rris_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.last) begin
          state_d = rris_pkg::ST_EMIT;
        end
      end
      rris_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = rris_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rris_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rris_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/rris_dp.sv
`timescale 1ns / 1ps

module rris_dp #(
  parameter int unsigned NUM_KEYS      = rris_pkg::NUM_KEYS_DEF,
  parameter int unsigned INTERVAL_BITS = rris_pkg::INTERVAL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                halt_i,
  input  logic                                cfg_valid_i,
  input  logic [rris_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rris_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                granted_o,
  output logic [rris_pkg::CHAN_W-1:0]         channel_number_o,
  output logic                                idle_scan_o,
  input  rris_pkg::dp_cmd_t                   cmd_i,
  output rris_pkg::dp_status_t                status_o
);

  localparam int unsigned PTR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [PTR_W-1:0] LAST_CH = PTR_W'(NUM_KEYS - 1);
  localparam logic [rris_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  // configuration
  logic [NUM_KEYS-1:0]           en_q, en_d;
  logic [rris_pkg::COUNT_W-1:0]  gap_q, gap_d;
  logic [INTERVAL_BITS-1:0]      ivl_q [NUM_KEYS];
  logic [INTERVAL_BITS-1:0]      ivl_d [NUM_KEYS];

  // scheduler state
  logic [rris_pkg::COUNT_W-1:0]  cnt_q [NUM_KEYS];
  logic [rris_pkg::COUNT_W-1:0]  cnt_d [NUM_KEYS];
  logic [PTR_W-1:0]              ptr_q, ptr_d;
  logic [rris_pkg::COUNT_W-1:0]  wait_q, wait_d;
  logic [PTR_W-1:0]              cur_q, cur_d;
  logic [PTR_W-1:0]              step_q, step_d;

  // staged result and output register
  logic                          res_grant_q, res_grant_d;
  logic [rris_pkg::CHAN_W-1:0]   res_ch_q, res_ch_d;
  logic                          res_idle_q, res_idle_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_grant_q;
  logic [rris_pkg::CHAN_W-1:0]   out_ch_q;
  logic                          out_idle_q;

  logic                          hit;
  logic                          last;
  logic [PTR_W-1:0]              cur_next;

  assign hit      = en_q[cur_q] &&
                    (cnt_q[cur_q] >= rris_pkg::COUNT_W'(ivl_q[cur_q]));
  assign last     = (step_q == LAST_CH);
  assign cur_next = (cur_q == LAST_CH) ? '0 : cur_q + PTR_W'(1);

  assign status_o.skip     = (wait_q != '0) || halt_i;
  assign status_o.hit      = hit;
  assign status_o.last     = last;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // register writes
  always_comb begin
    en_d  = en_q;
    gap_d = gap_q;
    for (int c = 0; c < NUM_KEYS; c++) begin
      ivl_d[c] = ivl_q[c];
    end
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rris_pkg::CFG_ENABLE_MASK: en_d  = cfg_data_i[NUM_KEYS-1:0];
        rris_pkg::CFG_GLOBAL_IVL:  gap_d = cfg_data_i[rris_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
      for (int c = 0; c < NUM_KEYS; c++) begin
        if (cfg_index_i == rris_pkg::CFG_IDX_W'(32'(rris_pkg::CFG_IVL_0_3) +
                                                c / rris_pkg::SLOTS_PER_W)) begin
          ivl_d[c] = cfg_data_i[(c % rris_pkg::SLOTS_PER_W) * rris_pkg::SLOT_W +:
                                INTERVAL_BITS];
        end
      end
    end
  end

  // tick, scan and emit
  always_comb begin
    for (int c = 0; c < NUM_KEYS; c++) begin
      cnt_d[c] = cnt_q[c];
    end
    ptr_d       = ptr_q;
    wait_d      = wait_q;
    cur_d       = cur_q;
    step_d      = step_q;
    res_grant_d = res_grant_q;
    res_ch_d    = res_ch_q;
    res_idle_d  = res_idle_q;
    out_valid_d = out_valid_q;

    if (cmd_i.tick) begin
      for (int c = 0; c < NUM_KEYS; c++) begin
        if (cnt_q[c] != COUNT_MAX) begin
          cnt_d[c] = cnt_q[c] + rris_pkg::COUNT_W'(1);
        end
      end
      res_grant_d = 1'b0;
      res_ch_d    = '0;
      res_idle_d  = 1'b0;
      cur_d       = ptr_q;
      step_d      = '0;
      if (wait_q != '0) begin
        wait_d = wait_q - rris_pkg::COUNT_W'(1);
      end
    end

    if (cmd_i.scan) begin
      if (hit) begin
        cnt_d[cur_q] = '0;
        ptr_d        = cur_next;
        wait_d       = gap_q;
        res_grant_d  = 1'b1;
        res_ch_d     = rris_pkg::CHAN_W'(cur_q) + rris_pkg::CHAN_W'(1);
      end else if (last) begin
        wait_d     = rris_pkg::IDLE_WAIT_MS;
        res_idle_d = 1'b1;
      end else begin
        cur_d  = cur_next;
        step_d = step_q + PTR_W'(1);
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      gap_q       <= '0;
      ptr_q       <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_KEYS; c++) begin
        ivl_q[c] <= '0;
        cnt_q[c] <= COUNT_MAX;
      end
    end else begin
      en_q        <= en_d;
      gap_q       <= gap_d;
      ptr_q       <= ptr_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      for (int c = 0; c < NUM_KEYS; c++) begin
        ivl_q[c] <= ivl_d[c];
        cnt_q[c] <= cnt_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    step_q      <= step_d;
    res_grant_q <= res_grant_d;
    res_ch_q    <= res_ch_d;
    res_idle_q  <= res_idle_d;
    if (cmd_i.emit) begin
      out_grant_q <= res_grant_q;
      out_ch_q    <= res_ch_q;
      out_idle_q  <= res_idle_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_o        = out_grant_q;
  assign channel_number_o = out_ch_q;
  assign idle_scan_o      = out_idle_q;

endmodule

>>> rtl/rris_checker.sv
`timescale 1ns / 1ps

module rris_checker #(
  parameter int unsigned NUM_KEYS = rris_pkg::NUM_KEYS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        granted_i,
  input logic [rris_pkg::CHAN_W-1:0] channel_number_i,
  input logic                        idle_scan_i
);

  // a grant and an empty scan never share a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(granted_i && idle_scan_i))
    else $error("grant and idle scan in one beat");

  // channel number is nonzero exactly on a grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (granted_i == (channel_number_i != '0)))
    else $error("channel number does not match grant");

  // granted channel exists
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && granted_i |-> 32'(channel_number_i) <= NUM_KEYS)
    else $error("granted channel out of range");

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(granted_i) &&
      $stable(channel_number_i) && $stable(idle_scan_i))
    else $error("result beat changed under stall");

endmodule

bind round_robin_interval_scheduler_top rris_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_rris_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .granted_i        (granted_o),
  .channel_number_i (channel_number_o),
  .idle_scan_i      (idle_scan_o)
);

>>> test/rris_grant_checker.sv
`timescale 1ns / 1ps

module rris_grant_checker
  import rris_pkg::*;
#(
  parameter int unsigned NUM_KEYS      = NUM_KEYS_DEF,
  parameter int unsigned INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_valid_i,
  input  logic                  tick_ready_i,
  input  logic                  halt_i,
  input  logic                  result_valid_i,
  input  logic                  result_ready_i,
  input  logic                  granted_i,
  input  logic [CHAN_W-1:0]     channel_number_i,
  input  logic                  idle_scan_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic              granted;
    logic [CHAN_W-1:0] channel;
    logic              idle_scan;
  } grant_t;

  // shadow registers
  logic [MASK_W-1:0]     enable_mask;
  logic [COUNT_W-1:0]    global_ivl;
  logic [CFG_DATA_W-1:0] ivl_words [3];

  // shadow state
  logic [COUNT_W-1:0]    elapsed_ms [NUM_KEYS];
  logic [CHAN_W-1:0]     next_chan;
  logic [COUNT_W-1:0]    hold_ms;

  grant_t      due_grants [$];
  grant_t      seen, want;
  int unsigned mismatches;

  function automatic logic [SLOT_W-1:0] interval_of(input int unsigned ch);
    logic [CFG_DATA_W-1:0] word;
    logic [SLOT_W-1:0]     slot;
    word = ivl_words[ch / SLOTS_PER_W];
    slot = word[(ch % SLOTS_PER_W) * SLOT_W +: SLOT_W];
    return slot & ~({SLOT_W{1'b1}} << INTERVAL_BITS);
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (cfg_index_e'(idx))
      CFG_ENABLE_MASK: enable_mask = data[MASK_W-1:0];
      CFG_GLOBAL_IVL:  global_ivl = data[COUNT_W-1:0];
      CFG_IVL_0_3:     ivl_words[0] = data;
      CFG_IVL_4_7:     ivl_words[1] = data;
      CFG_IVL_8_11:    ivl_words[2] = data;
      default: ;
    endcase
  endfunction

  // one millisecond tick: age every count, then wait, halt or scan
  function automatic grant_t advance_tick(input logic halt);
    grant_t      r;
    int unsigned ch;
    r = '0;
    for (int unsigned c = 0; c < NUM_KEYS; c++)
      if (elapsed_ms[c] != {COUNT_W{1'b1}}) elapsed_ms[c] = elapsed_ms[c] + 1'b1;
    if (hold_ms != '0) begin
      hold_ms = hold_ms - 1'b1;
      return r;
    end
    if (halt) return r;
    for (int unsigned k = 0; k < NUM_KEYS; k++) begin
      ch = (next_chan + k) % NUM_KEYS;
      if (enable_mask[ch] && elapsed_ms[ch] >= interval_of(ch)) begin
        elapsed_ms[ch] = '0;
        next_chan      = CHAN_W'((ch + 1) % NUM_KEYS);
        hold_ms        = global_ivl;
        r.granted      = 1'b1;
        r.channel      = CHAN_W'(ch + 1);
        return r;
      end
    end
    hold_ms     = IDLE_WAIT_MS;
    r.idle_scan = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_mask = '0;
      global_ivl  = '0;
      for (int i = 0; i < 3; i++) ivl_words[i] = '0;
      for (int unsigned c = 0; c < NUM_KEYS; c++) elapsed_ms[c] = {COUNT_W{1'b1}};
      next_chan  = '0;
      hold_ms    = '0;
      mismatches = 0;
      due_grants.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      // compare before queueing, so a stray result never meets this edge's tick
      if (result_valid_i && result_ready_i) begin
        seen = '{granted_i, channel_number_i, idle_scan_i};
        if (due_grants.size() == 0) begin
          $error("result beat with no tick pending: granted %0d channel_number %0d idle_scan %0d",
                 seen.granted, seen.channel, seen.idle_scan);
          mismatches++;
        end else begin
          want = due_grants.pop_front();
          if (seen.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, seen.granted);
            mismatches++;
          end
          if (seen.channel !== want.channel) begin
            $error("channel_number: expected %0d, got %0d", want.channel, seen.channel);
            mismatches++;
          end
          if (seen.idle_scan !== want.idle_scan) begin
            $error("idle_scan: expected %0d, got %0d", want.idle_scan, seen.idle_scan);
            mismatches++;
          end
        end
      end
      if (tick_valid_i && tick_ready_i) due_grants.push_back(advance_tick(halt_i));
      fail_count_o <= mismatches;
      pending_o    <= due_grants.size();
    end
  end

endmodule

>>> test/round_robin_interval_scheduler_top_test.sv
`timescale 1ns / 1ps

module round_robin_interval_scheduler_top_test;
  import rris_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 1000;
  // longest tick: accept and emit states plus one compare per channel, with margin
  localparam int unsigned TAIL_CYCLES = 2 * (2 + NUM_KEYS_DEF);
  localparam int unsigned RANDOM_PHASES = 14;
  // mask bits that name no channel
  localparam logic [MASK_W-1:0] ABSENT_BITS = ~((MASK_W'(1) << NUM_KEYS_DEF) - 1'b1);

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  halt_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  granted_o;
  logic [CHAN_W-1:0]     channel_number_o;
  logic                  idle_scan_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned mismatch_count;
  int unsigned open_ticks;
  int unsigned quiet_cycles;

  ready_mode_e ready_mode;
  logic [5:0]  ready_phase;

  round_robin_interval_scheduler_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .halt_i           (halt_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_o        (granted_o),
    .channel_number_o (channel_number_o),
    .idle_scan_o      (idle_scan_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // watches all three channels, predicts every tick and compares each result beat
  rris_grant_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (in_valid_i),
    .tick_ready_i     (in_ready_o),
    .halt_i           (halt_i),
    .result_valid_i   (out_valid_o),
    .result_ready_i   (out_ready_i),
    .granted_i        (granted_o),
    .channel_number_i (channel_number_o),
    .idle_scan_i      (idle_scan_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (mismatch_count),
    .pending_o        (open_ticks)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side back-pressure: a random new mode each time the phase counter wraps, one of
  // always ready, coin flips, sparse acceptance or a fixed one-in-four pattern
  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 1'b1;
    if (ready_phase == '1) ready_mode <= ready_mode_e'($urandom_range(3, 0));
    case (ready_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= 1'($urandom_range(1, 0));
      RDY_SPARSE: out_ready_i <= ($urandom_range(7, 0) == 0);
      default:    out_ready_i <= (ready_phase[1:0] == 2'b11);
    endcase
  end

  // one tick beat; valid is left high so a following beat needs no re-raise
  task automatic tick_beat(input logic halt);
    in_valid_i <= 1'b1;
    halt_i     <= halt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // random ticks in bursts, with gaps of random length, sometimes none, between bursts
  task automatic send_ticks(input int unsigned count, input int unsigned halt_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(40, 1);
      gap   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        tick_beat($urandom_range(99, 0) < halt_pct);
        sent++;
      end
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        halt_i     <= 1'($urandom_range(1, 0));  // junk on the idle payload
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // stop sending and wait for every outstanding result beat
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_ticks != 0) @(posedge clk_i);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // write all five registers back to back, junk in the unused high bits;
  // optionally one write to an index past the last register, which must be dropped
  task automatic program_regs(input logic [MASK_W-1:0]     mask,
                              input logic [COUNT_W-1:0]    global_ms,
                              input logic [CFG_DATA_W-1:0] keys_lo,
                              input logic [CFG_DATA_W-1:0] keys_mid,
                              input logic [CFG_DATA_W-1:0] keys_hi,
                              input logic                  stray);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom(), $urandom()};
    data[MASK_W-1:0] = mask;
    cfg_beat(CFG_ENABLE_MASK, data);
    data = {$urandom(), $urandom()};
    data[COUNT_W-1:0] = global_ms;
    cfg_beat(CFG_GLOBAL_IVL, data);
    cfg_beat(CFG_IVL_0_3, keys_lo);
    cfg_beat(CFG_IVL_4_7, keys_mid);
    cfg_beat(CFG_IVL_8_11, keys_hi);
    if (stray)
      cfg_beat(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_IVL_8_11 + 1)),
               {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;
  endtask

  // minimum interval for one channel: mostly short, some random, all-ones and zero
  function automatic logic [SLOT_W-1:0] pick_interval();
    case ($urandom_range(9, 0))
      0:       return '1;
      1:       return SLOT_W'($urandom());
      2:       return '0;
      default: return SLOT_W'($urandom_range(24, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_keys();
    return {pick_interval(), pick_interval(), pick_interval(), pick_interval()};
  endfunction

  // global gap: mostly a few ms so the scan runs often, rarely a full 16-bit value
  function automatic logic [COUNT_W-1:0] pick_global();
    case ($urandom_range(11, 0))
      0:       return COUNT_W'($urandom());
      1, 2:    return COUNT_W'($urandom_range(40, 7));
      default: return COUNT_W'($urandom_range(6, 0));
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return MASK_W'($urandom());
    endcase
  endfunction

  // watchdog: ends the run once no beat has moved on any channel for too long
  initial begin
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("round_robin_interval_scheduler_top regression: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    halt_i      = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ENABLE_MASK;
    cfg_data_i  = '0;
    ready_mode  = RDY_ALWAYS;
    ready_phase = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: a halted tick scans nothing and the counts stay saturated
    tick_beat(1'b1);
    drain_results();

    // every channel enabled (absent bits too), zero intervals, no global gap:
    // saturated counts let each channel in turn, then the pointer wraps;
    // one halted tick in the middle and a write to an unused index
    program_regs('1, '0, '0, '0, '0, 1'b1);
    for (int i = 0; i < 12; i++) tick_beat(i == 4);
    drain_results();

    // only absent bits set: the scan finds nothing, then the idle wait
    // counts down, halted or not
    program_regs(ABSENT_BITS, COUNT_W'(3), pick_keys(), pick_keys(), pick_keys(), 1'b0);
    tick_beat(1'b0);
    tick_beat(1'b1);
    tick_beat(1'b0);
    tick_beat(1'b0);
    drain_results();

    // random register sets, random ticks
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_regs(pick_mask(), pick_global(), pick_keys(), pick_keys(), pick_keys(),
                   1'($urandom_range(1, 0)));
      send_ticks($urandom_range(150, 100), $urandom_range(3, 0) * 12);
      drain_results();
    end

    // largest global gap: one grant, then the wait simply runs
    program_regs('1, '1, {$urandom(), $urandom()}, {$urandom(), $urandom()}, '0, 1'b1);
    send_ticks(6, 0);
    drain_results();

    // let any late or extra result beat show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && open_ticks == 0)
      $display("round_robin_interval_scheduler_top regression: pass");
    else
      $display("round_robin_interval_scheduler_top regression: fail");
    $finish;
  end

endmodule
